// File: src/arpr_pkg.sv
package arpr_pkg;

	localparam int CACHE_ENTRIES    = 16;
	localparam int PENDING_REQUESTS = 8;
	localparam int WAITING_DGRAMS   = 16;
	localparam int MAX_RESULTS      = 16;
	localparam int FQ_DEPTH         = 2;

	localparam int CI_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int RI_W  = (PENDING_REQUESTS > 1) ? $clog2(PENDING_REQUESTS) : 1;
	localparam int WI_W  = (WAITING_DGRAMS > 1) ? $clog2(WAITING_DGRAMS) : 1;
	localparam int SI_A  = (CI_W > RI_W) ? CI_W : RI_W;
	localparam int SI_W  = (SI_A > WI_W) ? SI_A : WI_W;
	localparam int WC_W  = $clog2(WAITING_DGRAMS + 1);
	localparam int RC_W  = $clog2(MAX_RESULTS + 1);
	localparam int FQ_W  = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int FC_W  = $clog2(FQ_DEPTH + 1);

	localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] ETH_IPV4    = 16'h0800;
	localparam logic [15:0] ETH_ARP     = 16'h0806;
	localparam logic [15:0] OPC_REQUEST = 16'd1;
	localparam logic [15:0] OPC_REPLY   = 16'd2;
	localparam logic [15:0] TTL_RESET   = 16'd30000;
	localparam logic [15:0] RETRY_RESET = 16'd5000;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RECV = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] REG_OWN_MAC = 2'd0;
	localparam logic [1:0] REG_OWN_IP  = 2'd1;
	localparam logic [1:0] REG_TTL     = 2'd2;
	localparam logic [1:0] REG_RETRY   = 2'd3;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_REQUEST  = 3'd1,
		ACT_REPLY    = 3'd2,
		ACT_TRANSMIT = 3'd3,
		ACT_DELIVER  = 3'd4,
		ACT_DROP     = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		K_SILENT    = 3'd0,
		K_SEND      = 3'd1,
		K_DELIVER   = 3'd2,
		K_ARP_REQ   = 3'd3,
		K_ARP_REPLY = 3'd4,
		K_ARP_OTHER = 3'd5,
		K_TICK      = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  handle;
		logic [31:0] ip;
		logic [47:0] mac;
		logic        tip_own;
		logic [15:0] elapsed;
	} item_t;

	typedef struct packed {
		action_t     action;
		logic [47:0] dest_mac;
		logic [31:0] target_ip;
		logic [47:0] target_mac;
		logic [7:0]  handle;
	} result_t;

endpackage

// File: src/arpr_front.sv
module arpr_front import arpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  dgram_handle,
	input  logic [31:0] gateway_ip,
	input  logic [47:0] frame_dst_mac,
	input  logic [15:0] frame_ethertype,
	input  logic        payload_ok,
	input  logic [15:0] arp_opcode,
	input  logic [47:0] arp_sender_mac,
	input  logic [31:0] arp_sender_ip,
	input  logic [31:0] arp_target_ip_in,
	input  logic [15:0] elapsed_ms,
	input  logic [47:0] own_mac,
	input  logic [31:0] own_ip,
	output item_t       item,
	output logic        item_valid,
	input  logic        item_pop
);

	item_t            new_item;
	kind_t            kind;
	item_t            fifo_q [FQ_DEPTH];
	logic [FQ_W-1:0]  wr_q;
	logic [FQ_W-1:0]  rd_q;
	logic [FC_W-1:0]  count_q;
	logic             push;

	// classify the item
	always_comb begin
		kind = K_SILENT;
		unique case (operation)
			OP_SEND: kind = K_SEND;
			OP_TICK: kind = K_TICK;
			OP_RECV: begin
				if ((frame_dst_mac == own_mac || frame_dst_mac == BCAST_MAC) && payload_ok) begin
					if (frame_ethertype == ETH_IPV4) begin
						kind = K_DELIVER;
					end else if (frame_ethertype == ETH_ARP) begin
						if (arp_opcode == OPC_REQUEST) kind = K_ARP_REQ;
						else if (arp_opcode == OPC_REPLY) kind = K_ARP_REPLY;
						else kind = K_ARP_OTHER;
					end
				end
			end
			default: kind = K_SILENT;
		endcase
	end

	always_comb begin
		new_item.kind    = kind;
		new_item.handle  = dgram_handle;
		new_item.ip      = (operation == OP_SEND) ? gateway_ip : arp_sender_ip;
		new_item.mac     = arp_sender_mac;
		new_item.tip_own = (arp_target_ip_in == own_ip);
		new_item.elapsed = elapsed_ms;
	end

	assign busy       = (count_q == FC_W'(FQ_DEPTH));
	assign push       = start && !busy;
	assign item_valid = (count_q != '0);
	assign item       = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == FQ_W'(FQ_DEPTH - 1)) ? '0 : wr_q + FQ_W'(1);
			if (item_pop) rd_q <= (rd_q == FQ_W'(FQ_DEPTH - 1)) ? '0 : rd_q + FQ_W'(1);
			if (push && !item_pop) count_q <= count_q + FC_W'(1);
			else if (!push && item_pop) count_q <= count_q - FC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= new_item;
	end

endmodule

// File: src/arpr_back.sv
module arpr_back import arpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_valid,
	output logic        item_pop,
	input  logic [15:0] mapping_ttl_ms,
	input  logic [15:0] arp_retry_ms,
	output result_t     res,
	output logic        res_valid,
	output logic        res_last
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CSCAN = 7'b0000010,
		ST_CWR   = 7'b0000100,
		ST_RSCAN = 7'b0001000,
		ST_RWR   = 7'b0010000,
		ST_WSCAN = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	function automatic result_t mk(action_t a, logic [47:0] dm, logic [31:0] tip,
		logic [47:0] tm, logic [7:0] h);
		result_t r;
		r.action     = a;
		r.dest_mac   = dm;
		r.target_ip  = tip;
		r.target_mac = tm;
		r.handle     = h;
		return r;
	endfunction

	state_t state_q;
	item_t  cur_q;

	logic [CACHE_ENTRIES-1:0]    c_valid_q;
	logic [31:0]                 c_ip_q  [CACHE_ENTRIES];
	logic [47:0]                 c_mac_q [CACHE_ENTRIES];
	logic [15:0]                 c_age_q [CACHE_ENTRIES];
	logic [PENDING_REQUESTS-1:0] r_valid_q;
	logic [31:0]                 r_ip_q  [PENDING_REQUESTS];
	logic [15:0]                 r_age_q [PENDING_REQUESTS];
	logic [31:0]                 w_ip_q  [WAITING_DGRAMS];
	logic [7:0]                  w_hdl_q [WAITING_DGRAMS];

	logic [SI_W-1:0] idx_q, match_q, free_q, old_q;
	logic            found_q, free_v_q;
	logic [15:0]     old_age_q;
	logic [WC_W-1:0] wcnt_q, wptr_q;
	logic [RC_W-1:0] rel_n_q;
	logic            drop_q, hold_v_q;
	result_t         hold_q;
	logic            res_valid_q, res_last_q;
	result_t         res_q;

	logic [CI_W-1:0] ci, cslot;
	logic [RI_W-1:0] ri, rslot;
	logic [WI_W-1:0] wi;
	logic            c_hit, r_hit, w_hit, c_expire, r_expire, c_last, r_last, w_last;
	logic [16:0]     c_sum, r_sum;
	logic            c_age_we, c_fill, r_age_we, r_fill, w_push, w_move;
	logic            emit_v, emit_last;
	result_t         emit_r;

	assign ci    = idx_q[CI_W-1:0];
	assign ri    = idx_q[RI_W-1:0];
	assign wi    = idx_q[WI_W-1:0];
	assign c_hit = c_valid_q[ci] && (c_ip_q[ci] == cur_q.ip);
	assign r_hit = r_valid_q[ri] && (r_ip_q[ri] == cur_q.ip);
	assign w_hit = (w_ip_q[wi] == cur_q.ip) && (rel_n_q < RC_W'(MAX_RESULTS));
	assign c_sum = {1'b0, c_age_q[ci]} + {1'b0, cur_q.elapsed};
	assign r_sum = {1'b0, r_age_q[ri]} + {1'b0, cur_q.elapsed};
	assign c_expire = c_sum > {1'b0, mapping_ttl_ms};
	assign r_expire = r_sum > {1'b0, arp_retry_ms};
	assign c_last = (idx_q == SI_W'(CACHE_ENTRIES - 1));
	assign r_last = (idx_q == SI_W'(PENDING_REQUESTS - 1));
	assign w_last = (WC_W'(idx_q) + WC_W'(1) == wcnt_q);

	// learn slot: matching entry, else first free, else oldest
	assign cslot = found_q ? match_q[CI_W-1:0] : (free_v_q ? free_q[CI_W-1:0] : old_q[CI_W-1:0]);
	assign rslot = free_v_q ? free_q[RI_W-1:0] : old_q[RI_W-1:0];

	assign item_pop = (state_q == ST_IDLE) && item_valid;

	assign c_age_we = (state_q == ST_CSCAN) && (cur_q.kind == K_TICK) && c_valid_q[ci] && !c_expire;
	assign c_fill   = (state_q == ST_CWR);
	assign r_age_we = (state_q == ST_RSCAN) && (cur_q.kind == K_TICK) && r_valid_q[ri] && !r_expire;
	assign r_fill   = (state_q == ST_RWR) && !found_q;
	assign w_push   = (state_q == ST_CSCAN) && (cur_q.kind == K_SEND) && !c_hit && c_last
		&& (wcnt_q < WC_W'(WAITING_DGRAMS));
	assign w_move   = (state_q == ST_WSCAN) && !w_hit;

	// result emission
	always_comb begin
		emit_v    = 1'b0;
		emit_last = 1'b0;
		emit_r    = mk(ACT_NONE, '0, '0, '0, '0);
		if (state_q == ST_WSCAN && w_hit && hold_v_q) begin
			emit_v = 1'b1;
			emit_r = hold_q;
		end else if (state_q == ST_OUT) begin
			emit_v = 1'b1;
			if (drop_q) begin
				emit_last = !hold_v_q;
				emit_r    = mk(ACT_DROP, '0, '0, '0, cur_q.handle);
			end else begin
				emit_last = 1'b1;
				if (hold_v_q) emit_r = hold_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			c_valid_q   <= '0;
			r_valid_q   <= '0;
			idx_q       <= '0;
			match_q     <= '0;
			free_q      <= '0;
			old_q       <= '0;
			found_q     <= 1'b0;
			free_v_q    <= 1'b0;
			old_age_q   <= '0;
			wcnt_q      <= '0;
			wptr_q      <= '0;
			rel_n_q     <= '0;
			drop_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			hold_q      <= mk(ACT_NONE, '0, '0, '0, '0);
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
			res_q       <= mk(ACT_NONE, '0, '0, '0, '0);
		end else begin
			res_valid_q <= emit_v;
			res_last_q  <= emit_last;
			res_q       <= emit_r;
			unique case (state_q)
				ST_IDLE: begin
					idx_q    <= '0;
					drop_q   <= 1'b0;
					hold_v_q <= 1'b0;
					rel_n_q  <= '0;
					wptr_q   <= '0;
					if (item_valid) begin
						unique case (item.kind)
							K_DELIVER: begin
								hold_v_q <= 1'b1;
								hold_q   <= mk(ACT_DELIVER, '0, '0, '0, item.handle);
								state_q  <= ST_OUT;
							end
							K_SILENT: state_q <= ST_OUT;
							default:  state_q <= ST_CSCAN;
						endcase
					end
				end
				ST_CSCAN: begin
					if (idx_q == '0) begin
						found_q   <= c_hit;
						match_q   <= idx_q;
						free_v_q  <= !c_valid_q[ci];
						free_q    <= idx_q;
						old_q     <= idx_q;
						old_age_q <= c_age_q[ci];
					end else begin
						if (c_hit && !found_q) begin
							found_q <= 1'b1;
							match_q <= idx_q;
						end
						if (!c_valid_q[ci] && !free_v_q) begin
							free_v_q <= 1'b1;
							free_q   <= idx_q;
						end
						if (c_valid_q[ci] && c_age_q[ci] > old_age_q) begin
							old_q     <= idx_q;
							old_age_q <= c_age_q[ci];
						end
					end
					if (cur_q.kind == K_TICK && c_valid_q[ci] && c_expire) c_valid_q[ci] <= 1'b0;
					if (cur_q.kind == K_SEND && c_hit) begin
						hold_v_q <= 1'b1;
						hold_q   <= mk(ACT_TRANSMIT, c_mac_q[ci], '0, '0, cur_q.handle);
						state_q  <= ST_OUT;
					end else if (c_last) begin
						idx_q <= '0;
						if (cur_q.kind == K_SEND) begin
							if (w_push) wcnt_q <= wcnt_q + WC_W'(1);
							else drop_q <= 1'b1;
							state_q <= ST_RSCAN;
						end else if (cur_q.kind == K_TICK) begin
							state_q <= ST_RSCAN;
						end else begin
							state_q <= ST_CWR;
						end
					end else begin
						idx_q <= idx_q + SI_W'(1);
					end
				end
				ST_CWR: begin
					c_valid_q[cslot] <= 1'b1;
					idx_q            <= '0;
					if (cur_q.kind == K_ARP_REQ) begin
						hold_v_q <= cur_q.tip_own;
						hold_q   <= mk(ACT_REPLY, cur_q.mac, cur_q.ip, cur_q.mac, '0);
						state_q  <= ST_OUT;
					end else if (cur_q.kind == K_ARP_REPLY && wcnt_q != '0) begin
						state_q <= ST_WSCAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_RSCAN: begin
					if (idx_q == '0) begin
						found_q   <= r_hit;
						free_v_q  <= !r_valid_q[ri];
						free_q    <= idx_q;
						old_q     <= idx_q;
						old_age_q <= r_age_q[ri];
					end else begin
						if (r_hit) found_q <= 1'b1;
						if (!r_valid_q[ri] && !free_v_q) begin
							free_v_q <= 1'b1;
							free_q   <= idx_q;
						end
						if (r_valid_q[ri] && r_age_q[ri] > old_age_q) begin
							old_q     <= idx_q;
							old_age_q <= r_age_q[ri];
						end
					end
					if (cur_q.kind == K_TICK && r_valid_q[ri] && r_expire) r_valid_q[ri] <= 1'b0;
					if (r_last) state_q <= (cur_q.kind == K_TICK) ? ST_OUT : ST_RWR;
					else idx_q <= idx_q + SI_W'(1);
				end
				ST_RWR: begin
					if (!found_q) begin
						r_valid_q[rslot] <= 1'b1;
						hold_v_q         <= 1'b1;
						hold_q           <= mk(ACT_REQUEST, BCAST_MAC, cur_q.ip, '0, '0);
					end
					state_q <= ST_OUT;
				end
				ST_WSCAN: begin
					if (w_hit) begin
						rel_n_q  <= rel_n_q + RC_W'(1);
						hold_v_q <= 1'b1;
						hold_q   <= mk(ACT_TRANSMIT, cur_q.mac, '0, '0, w_hdl_q[wi]);
					end else begin
						wptr_q <= wptr_q + WC_W'(1);
					end
					if (w_last) begin
						wcnt_q  <= w_hit ? wptr_q : wptr_q + WC_W'(1);
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + SI_W'(1);
					end
				end
				ST_OUT: begin
					if (drop_q) begin
						drop_q <= 1'b0;
						if (!hold_v_q) state_q <= ST_IDLE;
					end else begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) cur_q <= item;
		if (c_age_we) c_age_q[ci] <= c_sum[15:0];
		if (c_fill) begin
			c_ip_q[cslot]  <= cur_q.ip;
			c_mac_q[cslot] <= cur_q.mac;
			c_age_q[cslot] <= '0;
		end
		if (r_age_we) r_age_q[ri] <= r_sum[15:0];
		if (r_fill) begin
			r_ip_q[rslot]  <= cur_q.ip;
			r_age_q[rslot] <= '0;
		end
		if (w_push) begin
			w_ip_q[wcnt_q[WI_W-1:0]]  <= cur_q.ip;
			w_hdl_q[wcnt_q[WI_W-1:0]] <= cur_q.handle;
		end
		if (w_move) begin
			w_ip_q[wptr_q[WI_W-1:0]]  <= w_ip_q[wi];
			w_hdl_q[wptr_q[WI_W-1:0]] <= w_hdl_q[wi];
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;
	assign res_last  = res_last_q;

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("engine state not one-hot");
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_last_q |=> !res_valid_q) else $error("beat right after last");
	a_wcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= WC_W'(WAITING_DGRAMS)) else $error("wait queue count overflow");
`endif

endmodule

// File: src/arp_resolver_with_pending_queue_unit.sv
// arp resolver: sends, received frames and ticks enter on start/busy and each
// produces one or more result beats on result_valid, the final one flagged by
// last; results cannot be stalled. a two-entry command queue decouples the
// classifier from the engine, so busy rises only when both entries wait. the
// engine walks its tables one entry per clock, after an idle state that picks
// up the next command, and ends in an output state that gives the remaining
// beats: a tick walks the cache then the request table; a send that hits
// stops its cache walk at the matching entry; a send that misses walks the
// cache and the request table, and gives a drop beat when the wait queue is full;
// an arp frame walks the cache, and a reply then walks the queued datagrams
// (released beats come out during that walk); a delivered ipv4 frame or a
// filtered frame skips the tables. each beat leaves through an output
// register, in the cycle after the engine forms it. config writes are
// taken at any time but belong in idle periods.
module arp_resolver_with_pending_queue_unit import arpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  dgram_handle,
	input  logic [31:0] gateway_ip,
	input  logic [47:0] frame_dst_mac,
	input  logic [15:0] frame_ethertype,
	input  logic        payload_ok,
	input  logic [15:0] arp_opcode,
	input  logic [47:0] arp_sender_mac,
	input  logic [31:0] arp_sender_ip,
	input  logic [31:0] arp_target_ip_in,
	input  logic [15:0] elapsed_ms,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	output logic        result_valid,
	output logic [2:0]  action,
	output logic [47:0] dest_mac,
	output logic [31:0] arp_target_ip_out,
	output logic [47:0] arp_target_mac,
	output logic [7:0]  out_handle,
	output logic        last
);

	// configuration registers
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [15:0] ttl_q;
	logic [15:0] retry_q;

	// front to back command queue
	item_t   item;
	logic    item_valid;
	logic    item_pop;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
			ttl_q     <= TTL_RESET;
			retry_q   <= RETRY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_MAC: own_mac_q <= cfg_wdata;
				REG_OWN_IP:  own_ip_q  <= cfg_wdata[31:0];
				REG_TTL:     ttl_q     <= cfg_wdata[15:0];
				REG_RETRY:   retry_q   <= cfg_wdata[15:0];
				default:     ;
			endcase
		end
	end

	// classify and buffer incoming commands
	arpr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.dgram_handle     (dgram_handle),
		.gateway_ip       (gateway_ip),
		.frame_dst_mac    (frame_dst_mac),
		.frame_ethertype  (frame_ethertype),
		.payload_ok       (payload_ok),
		.arp_opcode       (arp_opcode),
		.arp_sender_mac   (arp_sender_mac),
		.arp_sender_ip    (arp_sender_ip),
		.arp_target_ip_in (arp_target_ip_in),
		.elapsed_ms       (elapsed_ms),
		.own_mac          (own_mac_q),
		.own_ip           (own_ip_q),
		.item             (item),
		.item_valid       (item_valid),
		.item_pop         (item_pop)
	);

	// table engine: cache, pending requests, waiting datagrams
	arpr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.item_valid     (item_valid),
		.item_pop       (item_pop),
		.mapping_ttl_ms (ttl_q),
		.arp_retry_ms   (retry_q),
		.res            (res),
		.res_valid      (result_valid),
		.res_last       (last)
	);

	// result beat fields
	assign action            = res.action;
	assign dest_mac          = res.dest_mac;
	assign arp_target_ip_out = res.target_ip;
	assign arp_target_mac    = res.target_mac;
	assign out_handle        = res.handle;

endmodule

// File: sim/arp_resolver_with_pending_queue_unit_test.sv
module arp_resolver_with_pending_queue_unit_test;
	import arpr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// one command as it enters the block
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  hnd;
		logic [31:0] hop;
		logic [47:0] dst;
		logic [15:0] etype;
		logic        ok;
		logic [15:0] opc;
		logic [47:0] smac;
		logic [31:0] sip;
		logic [31:0] tip;
		logic [15:0] el;
	} cmd_t;

	// one result beat
	typedef struct {
		action_t     act;
		logic [47:0] dmac;
		logic [31:0] tip;
		logic [47:0] tmac;
		logic [7:0]  hnd;
		logic        lst;
	} beat_t;

	// resolver state mirror plus the queue of beats still owed by the block
	class resolver_scoreboard;
		logic [47:0] own_mac;
		logic [31:0] own_ip;
		int unsigned ttl;
		int unsigned retry;
		bit          c_vld[CACHE_ENTRIES];
		logic [31:0] c_ip[CACHE_ENTRIES];
		logic [47:0] c_mac[CACHE_ENTRIES];
		int unsigned c_age[CACHE_ENTRIES];
		bit          r_vld[PENDING_REQUESTS];
		logic [31:0] r_ip[PENDING_REQUESTS];
		int unsigned r_age[PENDING_REQUESTS];
		bit          w_vld[WAITING_DGRAMS];
		logic [31:0] w_ip[WAITING_DGRAMS];
		logic [7:0]  w_hnd[WAITING_DGRAMS];
		beat_t       step_beats[$];
		beat_t       awaited_beats[$];
		int          errors;

		function new();
			own_mac = '0;
			own_ip  = '0;
			ttl     = 32'(TTL_RESET);
			retry   = 32'(RETRY_RESET);
			errors  = 0;
			foreach (c_vld[i]) c_vld[i] = 1'b0;
			foreach (r_vld[i]) r_vld[i] = 1'b0;
			foreach (w_vld[i]) w_vld[i] = 1'b0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [47:0] val);
			case (idx)
				REG_OWN_MAC: own_mac = val;
				REG_OWN_IP:  own_ip  = val[31:0];
				REG_TTL:     ttl     = 32'(val[15:0]);
				REG_RETRY:   retry   = 32'(val[15:0]);
				default:     ;
			endcase
		endfunction

		function void emit(action_t a, logic [47:0] dm, logic [31:0] ti, logic [47:0] tm,
				logic [7:0] h);
			beat_t b;
			if (step_beats.size() >= MAX_RESULTS) return;
			b.act = a; b.dmac = dm; b.tip = ti; b.tmac = tm; b.hnd = h; b.lst = 1'b0;
			step_beats.push_back(b);
		endfunction

		function void learn(logic [31:0] ip, logic [47:0] mac);
			int slot;
			int oldest;
			slot = -1;
			oldest = 0;
			// known sender refreshes in place
			foreach (c_vld[i]) begin
				if (c_vld[i] && c_ip[i] == ip) begin
					c_mac[i] = mac;
					c_age[i] = 0;
					return;
				end
			end
			foreach (c_vld[i]) begin
				if (!c_vld[i]) begin
					slot = i;
					break;
				end
				if (c_age[i] > c_age[oldest]) oldest = i;
			end
			if (slot < 0) slot = oldest;
			c_vld[slot] = 1'b1; c_ip[slot] = ip; c_mac[slot] = mac; c_age[slot] = 0;
		endfunction

		function void send(logic [7:0] h, logic [31:0] ip);
			bit queued;
			bit pend;
			int slot;
			int oldest;
			queued = 1'b0;
			pend = 1'b0;
			slot = -1;
			oldest = 0;
			foreach (c_vld[i]) begin
				if (c_vld[i] && c_ip[i] == ip) begin
					emit(ACT_TRANSMIT, c_mac[i], '0, '0, h);
					return;
				end
			end
			foreach (w_vld[i]) begin
				if (!w_vld[i]) begin
					w_vld[i] = 1'b1; w_ip[i] = ip; w_hnd[i] = h;
					queued = 1'b1;
					break;
				end
			end
			if (!queued) emit(ACT_DROP, '0, '0, '0, h);
			foreach (r_vld[i]) if (r_vld[i] && r_ip[i] == ip) pend = 1'b1;
			if (!pend) begin
				foreach (r_vld[i]) begin
					if (!r_vld[i]) begin
						slot = i;
						break;
					end
					if (r_age[i] > r_age[oldest]) oldest = i;
				end
				if (slot < 0) slot = oldest;
				r_vld[slot] = 1'b1; r_ip[slot] = ip; r_age[slot] = 0;
				emit(ACT_REQUEST, BCAST_MAC, ip, '0, '0);
			end
		endfunction

		// release matching datagrams in order and keep the queue packed
		function void release_waiting(logic [31:0] ip, logic [47:0] mac);
			int w;
			w = 0;
			for (int i = 0; i < WAITING_DGRAMS; i++) begin
				if (!w_vld[i]) continue;
				if (w_ip[i] == ip && step_beats.size() < MAX_RESULTS) begin
					emit(ACT_TRANSMIT, mac, '0, '0, w_hnd[i]);
					w_vld[i] = 1'b0;
				end else begin
					w_vld[w] = 1'b1; w_ip[w] = w_ip[i]; w_hnd[w] = w_hnd[i];
					if (w != i) w_vld[i] = 1'b0;
					w++;
				end
			end
		endfunction

		function void age_tables(int unsigned el);
			foreach (c_vld[i]) begin
				if (!c_vld[i]) continue;
				if (c_age[i] + el > ttl) c_vld[i] = 1'b0;
				else c_age[i] += el;
			end
			foreach (r_vld[i]) begin
				if (!r_vld[i]) continue;
				if (r_age[i] + el > retry) r_vld[i] = 1'b0;
				else r_age[i] += el;
			end
		endfunction

		// work out the beats one accepted command owes
		function void resolve_cmd(cmd_t c);
			step_beats.delete();
			if (c.op == OP_SEND) begin
				send(c.hnd, c.hop);
			end else if (c.op == OP_RECV) begin
				if ((c.dst == own_mac || c.dst == BCAST_MAC) && c.ok) begin
					if (c.etype == ETH_IPV4) begin
						emit(ACT_DELIVER, '0, '0, '0, c.hnd);
					end else if (c.etype == ETH_ARP) begin
						learn(c.sip, c.smac);
						if (c.opc == OPC_REQUEST) begin
							if (c.tip == own_ip) emit(ACT_REPLY, c.smac, c.sip, c.smac, '0);
						end else if (c.opc == OPC_REPLY) begin
							release_waiting(c.sip, c.smac);
						end
					end
				end
			end else if (c.op == OP_TICK) begin
				age_tables(32'(c.el));
			end
			if (step_beats.size() == 0) emit(ACT_NONE, '0, '0, '0, '0);
			step_beats[step_beats.size() - 1].lst = 1'b1;
			foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (awaited_beats.size() == 0) begin
				$error("result beat with nothing awaited: action %0d", got.act);
				errors++;
				return;
			end
			want = awaited_beats.pop_front();
			if (got.act !== want.act) begin
				$error("action: expected %0d, got %0d", want.act, got.act);
				errors++;
			end
			if (got.dmac !== want.dmac) begin
				$error("dest_mac: expected %h, got %h", want.dmac, got.dmac);
				errors++;
			end
			if (got.tip !== want.tip) begin
				$error("arp_target_ip_out: expected %h, got %h", want.tip, got.tip);
				errors++;
			end
			if (got.tmac !== want.tmac) begin
				$error("arp_target_mac: expected %h, got %h", want.tmac, got.tmac);
				errors++;
			end
			if (got.hnd !== want.hnd) begin
				$error("out_handle: expected %h, got %h", want.hnd, got.hnd);
				errors++;
			end
			if (got.lst !== want.lst) begin
				$error("last: expected %0b, got %0b", want.lst, got.lst);
				errors++;
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 4000;	// cycles with no handshake before giving up
	localparam int SETTLE     = 60;	// engine latency margin before config or end

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = '0;
	logic [7:0]  dgram_handle = '0;
	logic [31:0] gateway_ip = '0;
	logic [47:0] frame_dst_mac = '0;
	logic [15:0] frame_ethertype = '0;
	logic        payload_ok = 1'b0;
	logic [15:0] arp_opcode = '0;
	logic [47:0] arp_sender_mac = '0;
	logic [31:0] arp_sender_ip = '0;
	logic [31:0] arp_target_ip_in = '0;
	logic [15:0] elapsed_ms = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_wdata = '0;
	logic        result_valid;
	logic [2:0]  action;
	logic [47:0] dest_mac;
	logic [31:0] arp_target_ip_out;
	logic [47:0] arp_target_mac;
	logic [7:0]  out_handle;
	logic        last;

	resolver_scoreboard sb = new();
	int idle_cycles = 0;
	logic [31:0] ip_pool[8];

	arp_resolver_with_pending_queue_unit dut (.*);

	always #6 clk = ~clk;

	// result monitor and handshake watchdog
	always @(posedge clk) begin
		beat_t b;
		if (arst_n) begin
			if (result_valid) begin
				b.act = action_t'(action); b.dmac = dest_mac; b.tip = arp_target_ip_out;
				b.tmac = arp_target_mac; b.hnd = out_handle; b.lst = last;
				sb.check_beat(b);
			end
			if (result_valid || (start && !busy)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one command and hold it until the block takes the beat
	task automatic drive_cmd(cmd_t c, int gap);
		start <= 1'b1;
		operation <= c.op; dgram_handle <= c.hnd; gateway_ip <= c.hop;
		frame_dst_mac <= c.dst; frame_ethertype <= c.etype; payload_ok <= c.ok;
		arp_opcode <= c.opc; arp_sender_mac <= c.smac; arp_sender_ip <= c.sip;
		arp_target_ip_in <= c.tip; elapsed_ms <= c.el;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sb.resolve_cmd(c);
		// keep start high across back-to-back beats
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// lower start, wait out every owed beat, then the engine tail
	task automatic drain();
		start <= 1'b0;
		while (sb.awaited_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic cmd_t blank_cmd(logic [1:0] op);
		cmd_t c;
		c.op = op; c.hnd = '0; c.hop = '0; c.dst = sb.own_mac; c.etype = ETH_ARP;
		c.ok = 1'b1; c.opc = OPC_REQUEST; c.smac = '0; c.sip = '0; c.tip = '0; c.el = '0;
		return c;
	endfunction

	function automatic logic [47:0] rand_mac();
		return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
	endfunction

	// mostly well-formed traffic around a small pool of neighbors, some noise
	function automatic cmd_t random_cmd();
		cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		c = blank_cmd(OP_SEND);
		c.hnd = 8'($urandom_range(0, 255));
		c.hop = ($urandom_range(0, 5) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
		c.smac = rand_mac();
		// replies come only from the first six neighbors so the queue can fill
		c.sip = ($urandom_range(0, 4) == 0) ? $urandom() : ip_pool[$urandom_range(0, 5)];
		c.tip = ($urandom_range(0, 1) == 0) ? sb.own_ip : $urandom();
		c.el = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) :
			16'($urandom_range(0, 3000));
		c.dst = rand_mac();
		c.etype = 16'($urandom_range(0, 65535));
		c.ok = 1'($urandom_range(0, 1));
		c.opc = 16'($urandom_range(0, 65535));
		if (r < 38) begin
			c.op = OP_SEND;
		end else if (r < 82) begin
			c.op = OP_RECV;
			if ($urandom_range(0, 9) != 0) begin
				c.dst = $urandom_range(0, 1) ? sb.own_mac : BCAST_MAC;
				c.ok = ($urandom_range(0, 19) != 0);
				c.etype = ($urandom_range(0, 3) == 0) ? ETH_IPV4 : ETH_ARP;
				c.opc = $urandom_range(0, 2) ? OPC_REPLY : OPC_REQUEST;
			end
		end else if (r < 96) begin
			c.op = OP_TICK;
		end else begin
			c.op = 2'd3;
		end
		return c;
	endfunction

	task automatic random_phase(int count);
		repeat (count) drive_cmd(random_cmd(), pick_gap());
	endtask

	initial begin
		cmd_t c;
		foreach (ip_pool[i]) ip_pool[i] = $urandom();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_OWN_MAC, rand_mac());
		write_reg(REG_OWN_IP, 48'($urandom()));
		write_reg(REG_TTL, 48'(TTL_RESET));
		write_reg(REG_RETRY, 48'(RETRY_RESET));

		// directed: miss, pending miss, reply release, hit
		c = blank_cmd(OP_SEND); c.hnd = 8'h00; c.hop = ip_pool[0]; drive_cmd(c, 0);
		c.hnd = 8'hFF; drive_cmd(c, 1);
		c = blank_cmd(OP_RECV); c.opc = OPC_REPLY; c.sip = ip_pool[0];
		c.smac = 48'hFFFF_FFFF_FFFE; drive_cmd(c, 0);
		c = blank_cmd(OP_SEND); c.hnd = 8'h5A; c.hop = ip_pool[0]; drive_cmd(c, 2);
		// ipv4 delivery to own and broadcast, filtered, unparsed, unknown type
		c = blank_cmd(OP_RECV); c.etype = ETH_IPV4; c.hnd = 8'hA5; drive_cmd(c, 0);
		c.dst = BCAST_MAC; drive_cmd(c, 0);
		c.dst = ~sb.own_mac ^ 48'h1; drive_cmd(c, 0);
		c.dst = sb.own_mac; c.ok = 1'b0; drive_cmd(c, 0);
		c.ok = 1'b1; c.etype = 16'hFFFF; drive_cmd(c, 0);
		// arp request for us, for someone else, unknown opcode, known sender
		c = blank_cmd(OP_RECV); c.tip = sb.own_ip; c.sip = 32'hFFFF_FFFF;
		c.smac = rand_mac(); drive_cmd(c, 0);
		c.tip = ~sb.own_ip; drive_cmd(c, 3);
		c.opc = 16'hFFFF; c.smac = 48'h0; drive_cmd(c, 0);
		// unused operation, zero tick, tick that expires everything
		c = blank_cmd(2'd3); drive_cmd(c, 0);
		c = blank_cmd(OP_TICK); drive_cmd(c, 0);
		c.el = 16'hFFFF; drive_cmd(c, 0);
		c = blank_cmd(OP_SEND); c.hop = ip_pool[0]; c.hnd = 8'h11; drive_cmd(c, 0);
		drain();

		random_phase(100);
		drain();

		// zero limits: every tick with nonzero elapsed time expires, own mac and ip of zero
		write_reg(REG_TTL, 48'd0);
		write_reg(REG_RETRY, 48'd0);
		write_reg(REG_OWN_MAC, 48'h0);
		write_reg(REG_OWN_IP, 48'h0);
		random_phase(80);
		drain();

		// largest limits, broadcast own mac, all-ones own ip
		write_reg(REG_TTL, 48'hFFFF);
		write_reg(REG_RETRY, 48'hFFFF);
		write_reg(REG_OWN_MAC, BCAST_MAC);
		write_reg(REG_OWN_IP, 48'hFFFF_FFFF);
		random_phase(60);
		drain();

		write_reg(REG_TTL, 48'($urandom_range(1000, 8000)));
		write_reg(REG_RETRY, 48'($urandom_range(200, 2000)));
		write_reg(REG_OWN_MAC, rand_mac());
		random_phase(80);
		drain();

		if (sb.errors == 0 && sb.awaited_beats.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
